@@ src/swhsr_pkg.sv @@
// Shared types and constants for the single-wire humidity sensor reader.
// Used by swhsr_ctrl and the top level; depends on nothing else.
package swhsr_pkg;

	// frame layout
	localparam int FRAME_BITS = 40;
	localparam int BIT_IDX_W  = 6;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_PRE_HIGH_TIME    = 3'd0;
	localparam cfg_idx_t REG_START_LOW_TIME   = 3'd1;
	localparam cfg_idx_t REG_START_HIGH_TIME  = 3'd2;
	localparam cfg_idx_t REG_RELEASE_GAP_TIME = 3'd3;
	localparam cfg_idx_t REG_WAIT_TIMEOUT     = 3'd4;
	localparam cfg_idx_t REG_ONE_THRESHOLD    = 3'd5;

	// register reset values
	localparam logic [17:0] PRE_HIGH_RST    = 18'd250000;
	localparam logic [17:0] START_LOW_RST   = 18'd20000;
	localparam logic [7:0]  START_HIGH_RST  = 8'd40;
	localparam logic [7:0]  RELEASE_GAP_RST = 8'd10;
	localparam logic [15:0] WAIT_TIMEOUT_RST = 16'd4000;
	localparam logic [7:0]  ONE_THRESH_RST  = 8'd40;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_PRE_HIGH,
		PH_START_LOW,
		PH_START_HIGH,
		PH_GAP,
		PH_WAIT_HIGH,
		PH_WAIT_LOW,
		PH_BIT_LOW,
		PH_BIT_HIGH
	} phase_t;

	typedef struct packed {
		logic [17:0] pre_high_time;
		logic [17:0] start_low_time;
		logic [7:0]  start_high_time;
		logic [7:0]  release_gap_time;
		logic [15:0] wait_timeout;
		logic [7:0]  one_threshold;
	} cfg_t;

	typedef struct packed {
		logic       drive_enable;
		logic       drive_level;
		logic       busy_res;
		logic       read_done;
		logic       checksum_ok;
		logic [7:0] humidity;
		logic [7:0] temperature;
	} res_t;

endpackage

@@ src/single_wire_humidity_sensor_reader_unit.sv @@
// Top level of the single-wire humidity sensor reader: ports, configuration
// registers, input stage and result register. Depends on swhsr_pkg and swhsr_ctrl.
//
// Each input item is one microsecond tick with the sampled wire level and an
// optional start request; each item gives exactly one result item with the
// wire drive, busy, done/checksum flags and the last good humidity and
// temperature bytes, cleared when the sensor does not answer. The block takes
// one item per clock cycle while in_stall is low: an item is registered in the
// input stage, where the sequencer steps the read state, and its result is then
// registered in the output register. The input stage keeps accepting while one
// result waits to be taken; in_stall rises only when both the input stage and
// the result register are full and out_stall is high. Configuration writes take
// effect on the next cycle and are meant for idle periods only.
module single_wire_humidity_sensor_reader_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_write,
	input  logic [swhsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swhsr_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic                          line_level,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          drive_enable,
	output logic                          drive_level,
	output logic                          busy_res,
	output logic                          read_done,
	output logic                          checksum_ok,
	output logic [7:0]                    humidity,
	output logic [7:0]                    temperature
);
	import swhsr_pkg::*;

	cfg_t cfg_q;
	logic valid_s1, op_s1, line_s1;
	logic out_valid_q;
	res_t res_q;
	res_t res;
	logic step;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_high_time    <= PRE_HIGH_RST;
			cfg_q.start_low_time   <= START_LOW_RST;
			cfg_q.start_high_time  <= START_HIGH_RST;
			cfg_q.release_gap_time <= RELEASE_GAP_RST;
			cfg_q.wait_timeout     <= WAIT_TIMEOUT_RST;
			cfg_q.one_threshold    <= ONE_THRESH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PRE_HIGH_TIME:    cfg_q.pre_high_time    <= cfg_data;
				REG_START_LOW_TIME:   cfg_q.start_low_time   <= cfg_data;
				REG_START_HIGH_TIME:  cfg_q.start_high_time  <= cfg_data[7:0];
				REG_RELEASE_GAP_TIME: cfg_q.release_gap_time <= cfg_data[7:0];
				REG_WAIT_TIMEOUT:     cfg_q.wait_timeout     <= cfg_data[15:0];
				REG_ONE_THRESHOLD:    cfg_q.one_threshold    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// stage 1 item moves on when the result register is free or being drained
	assign step     = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & out_valid_q & out_stall;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1   <= op;
			line_s1 <= line_level;
		end
	end

	// sequencer
	swhsr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.op         (op_s1),
		.line_level (line_s1),
		.cfg        (cfg_q),
		.res        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign drive_enable = res_q.drive_enable;
	assign drive_level  = res_q.drive_level;
	assign busy_res     = res_q.busy_res;
	assign read_done    = res_q.read_done;
	assign checksum_ok  = res_q.checksum_ok;
	assign humidity     = res_q.humidity;
	assign temperature  = res_q.temperature;

endmodule

@@ src/swhsr_ctrl.sv @@
// Read sequencer: phase state machine, tick timer, pulse timing and frame checksum.
// Advances one tick per step; depends on swhsr_pkg.
module swhsr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             op,
	input  logic             line_level,
	input  swhsr_pkg::cfg_t  cfg,
	output swhsr_pkg::res_t  res
);
	import swhsr_pkg::*;

	phase_t               phase_q, phase_d;
	logic [17:0]          timer_q, timer_d;
	logic [15:0]          pw_q, pw_d;
	logic [BIT_IDX_W-1:0] idx_q, idx_d;
	logic [FRAME_BITS-1:0] frame_q, frame_d;
	logic [7:0]           hum_q, hum_d;
	logic [7:0]           temp_q, temp_d;
	logic                 done, ok;

	logic [17:0]           timer_inc;
	logic                  timed_out;
	logic [17:0]           drive_dur;
	logic [15:0]           pw_inc;
	logic [15:0]           pw_bit;
	logic                  bit_val;
	logic [FRAME_BITS-1:0] frame_shift;
	logic [BIT_IDX_W-1:0]  idx_inc;
	logic [7:0]            byte_sum;

	// shared timing, bit and checksum terms
	assign timer_inc = timer_q + 18'd1;
	assign timed_out = timer_inc > {2'b00, cfg.wait_timeout};
	assign pw_inc    = (pw_q == 16'hFFFF) ? pw_q : pw_q + 16'd1;
	assign pw_bit    = line_level ? pw_inc : pw_q;
	assign bit_val   = pw_bit > {8'h00, cfg.one_threshold};
	assign frame_shift = {frame_q[FRAME_BITS-2:0], bit_val};
	assign idx_inc   = idx_q + BIT_IDX_W'(1);
	assign byte_sum  = frame_shift[FRAME_BITS-1 -: 8] + frame_shift[FRAME_BITS-9 -: 8]
		+ frame_shift[FRAME_BITS-17 -: 8] + frame_shift[FRAME_BITS-25 -: 8];

	// length of the current drive phase
	always_comb begin
		case (phase_q)
			PH_PRE_HIGH:   drive_dur = cfg.pre_high_time;
			PH_START_LOW:  drive_dur = cfg.start_low_time;
			PH_START_HIGH: drive_dur = {10'd0, cfg.start_high_time};
			default:       drive_dur = {10'd0, cfg.release_gap_time};
		endcase
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		pw_d    = pw_q;
		idx_d   = idx_q;
		frame_d = frame_q;
		hum_d   = hum_q;
		temp_d  = temp_q;
		done    = 1'b0;
		ok      = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (op) begin
					phase_d = PH_PRE_HIGH;
					timer_d = '0;
					pw_d    = '0;
					idx_d   = '0;
					frame_d = '0;
				end
			end
			PH_PRE_HIGH, PH_START_LOW, PH_START_HIGH, PH_GAP: begin
				if (timer_inc >= drive_dur) begin
					timer_d = '0;
					case (phase_q)
						PH_PRE_HIGH:   phase_d = PH_START_LOW;
						PH_START_LOW:  phase_d = PH_START_HIGH;
						PH_START_HIGH: phase_d = PH_GAP;
						default:       phase_d = PH_WAIT_HIGH;
					endcase
				end else begin
					timer_d = timer_inc;
				end
			end
			PH_WAIT_HIGH: begin
				if (line_level) begin
					phase_d = PH_WAIT_LOW;
					timer_d = '0;
				end else if (timed_out) begin
					hum_d   = '0;
					temp_d  = '0;
					phase_d = PH_WAIT_LOW;
					timer_d = '0;
				end else begin
					timer_d = timer_inc;
				end
			end
			PH_WAIT_LOW: begin
				if (!line_level || timed_out) begin
					phase_d = PH_BIT_LOW;
					timer_d = '0;
				end else begin
					timer_d = timer_inc;
				end
			end
			PH_BIT_LOW: begin
				if (line_level) begin
					phase_d = PH_BIT_HIGH;
					timer_d = '0;
					pw_d    = 16'd1;
				end else if (timed_out) begin
					phase_d = PH_BIT_HIGH;
					timer_d = '0;
					pw_d    = '0;
				end else begin
					timer_d = timer_inc;
				end
			end
			PH_BIT_HIGH: begin
				if (line_level && !timed_out) begin
					pw_d    = pw_inc;
					timer_d = timer_inc;
				end else begin
					// end of bit: shift it in, close the frame after the last one
					frame_d = frame_shift;
					idx_d   = idx_inc;
					pw_d    = '0;
					timer_d = '0;
					if (idx_inc >= BIT_IDX_W'(FRAME_BITS)) begin
						done    = 1'b1;
						ok      = (byte_sum == frame_shift[7:0]);
						phase_d = PH_IDLE;
						if (ok) begin
							hum_d  = frame_shift[FRAME_BITS-1 -: 8];
							temp_d = frame_shift[FRAME_BITS-17 -: 8];
						end
					end else begin
						phase_d = PH_BIT_LOW;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				timer_d = '0;
			end
		endcase
	end

	// result fields reflect the state after the tick
	always_comb begin
		res.drive_enable = (phase_d == PH_PRE_HIGH) || (phase_d == PH_START_LOW)
			|| (phase_d == PH_START_HIGH) || (phase_d == PH_GAP);
		res.drive_level  = (phase_d == PH_PRE_HIGH) || (phase_d == PH_START_HIGH);
		res.busy_res     = (phase_d != PH_IDLE);
		res.read_done    = done;
		res.checksum_ok  = done & ok;
		res.humidity     = hum_d;
		res.temperature  = temp_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			pw_q    <= '0;
			idx_q   <= '0;
			frame_q <= '0;
			hum_q   <= '0;
			temp_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			pw_q    <= pw_d;
			idx_q   <= idx_d;
			frame_q <= frame_d;
			hum_q   <= hum_d;
			temp_q  <= temp_d;
		end
	end

endmodule
